/* design/bpm_pkg.sv */
package bpm_pkg;

  localparam int NUM_CELLS   = 4;
  localparam int CELL_FIELDS = 4;
  localparam int MON_CELLS   = (NUM_CELLS < CELL_FIELDS) ? NUM_CELLS : CELL_FIELDS;

  localparam int VOLT_W    = 13;
  localparam int TEMP_W    = 12;
  localparam int CUR_W     = 19;
  localparam int MS_W      = 16;
  localparam int CHG_LIM_W = 20;
  localparam int DIS_LIM_W = 21;
  localparam int COUNT_W   = 40;
  localparam int PROD_W    = CUR_W + MS_W + 1;
  localparam int SUM_W     = COUNT_W + 2;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 40;

  localparam logic [VOLT_W-1:0]           BAL_FLOOR_RST = 13'd3400;
  localparam logic [VOLT_W-1:0]           BAL_DELTA_RST = 13'd30;
  localparam logic [VOLT_W-1:0]           OVERVOLT_RST  = 13'd3650;
  localparam logic [VOLT_W-1:0]           UNDERVOLT_RST = 13'd2500;
  localparam logic signed [TEMP_W-1:0]    OVERTEMP_RST  = 12'sd550;
  localparam logic [CHG_LIM_W-1:0]        CHG_LIM_RST   = 20'd50000;
  localparam logic signed [DIS_LIM_W-1:0] DIS_LIM_RST   = -21'sd100000;
  localparam logic [COUNT_W-1:0]          CAPACITY_RST  = 40'd180000000000;
  localparam logic [COUNT_W-1:0]          COUNT_RST     = 40'd90000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAL_FLOOR = 3'd0,
    REG_BAL_DELTA = 3'd1,
    REG_OVERVOLT  = 3'd2,
    REG_UNDERVOLT = 3'd3,
    REG_OVERTEMP  = 3'd4,
    REG_CHG_LIM   = 3'd5,
    REG_DIS_LIM   = 3'd6,
    REG_CAPACITY  = 3'd7
  } cfg_reg_t;

  typedef logic [VOLT_W-1:0] volt_t;
  typedef volt_t [CELL_FIELDS-1:0] cells_t;

  typedef struct packed {
    logic [CELL_FIELDS-1:0] balance_mask;
    logic                   ov;
    logic                   uv;
    logic                   ot;
    logic                   occ;
    logic                   ocd;
  } eval_t;

endpackage

/* design/bpm_eval.sv */
module bpm_eval (
  input  bpm_pkg::cells_t                             cells,
  input  logic signed [bpm_pkg::TEMP_W-1:0]           pack_temperature,
  input  logic signed [bpm_pkg::CUR_W-1:0]            pack_current,
  input  logic [bpm_pkg::VOLT_W-1:0]                  balance_floor_mv,
  input  logic [bpm_pkg::VOLT_W-1:0]                  balance_delta_mv,
  input  logic [bpm_pkg::VOLT_W-1:0]                  overvolt_mv,
  input  logic [bpm_pkg::VOLT_W-1:0]                  undervolt_mv,
  input  logic signed [bpm_pkg::TEMP_W-1:0]           overtemp_limit,
  input  logic [bpm_pkg::CHG_LIM_W-1:0]               charge_current_limit,
  input  logic signed [bpm_pkg::DIS_LIM_W-1:0]        discharge_current_limit,
  output bpm_pkg::eval_t                              result
);
  import bpm_pkg::*;

  volt_t                        lowest;
  logic signed [DIS_LIM_W-1:0]  cur_ext;
  logic signed [DIS_LIM_W-1:0]  chg_lim_ext;

  always_comb begin
    lowest = cells[0];
    for (int i = 1; i < MON_CELLS; i++) begin
      if (cells[i] < lowest) begin
        lowest = cells[i];
      end
    end
  end

  assign cur_ext     = {{(DIS_LIM_W - CUR_W){pack_current[CUR_W-1]}}, pack_current};
  assign chg_lim_ext = {1'b0, charge_current_limit};

  always_comb begin
    result = '0;
    for (int i = 0; i < MON_CELLS; i++) begin
      // cells[i] >= lowest, so the difference cannot wrap
      if (cells[i] > balance_floor_mv && volt_t'(cells[i] - lowest) > balance_delta_mv) begin
        result.balance_mask[i] = 1'b1;
      end
      if (cells[i] > overvolt_mv) begin
        result.ov = 1'b1;
      end
      if (cells[i] < undervolt_mv) begin
        result.uv = 1'b1;
      end
    end
    result.ot  = pack_temperature > overtemp_limit;
    result.occ = cur_ext > chg_lim_ext;
    result.ocd = cur_ext < discharge_current_limit;
  end

endmodule

/* design/battery_pack_monitor.sv */
// Battery pack monitor: protection flags, cell balancing and charge counting.
// s_axis carries one tick per transaction: four cell voltages, pack temperature,
// pack current and elapsed milliseconds. m_axis returns one result per tick:
// balance mask, fault bits, switch enables and the clamped charge count (mA-ms).
// The cfg port writes the eight limit/capacity registers; writes take effect at
// once and should only be made with no tick in flight.
// The input register feeds the threshold flags, the 19x17 current*time product and
// the charge count add and clamp, all combinational, into the result register, which
// drives m_axis_tvalid. One tick per cycle is sustained while m_axis_tready is high;
// the count loop is the product, one 42-bit add and the clamp compare.
// Each stage moves on when the stage after it is empty or moving, so a stalled
// m_axis fills both registers before s_axis_tready drops; no transaction is lost.
// Reset loads the limit/capacity registers with their defaults, sets the charge
// count to half the default capacity and empties both stages.
module battery_pack_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cell_voltage_0, cell_voltage_1, cell_voltage_2, cell_voltage_3,
  // pack_temperature, pack_current, elapsed_ms, zero pad
  input  logic [bpm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // balance_mask, fault_bits, charge_enable, discharge_enable, charge_level, zero pad
  output logic [bpm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bpm_pkg::*;

  // configuration
  logic [VOLT_W-1:0]           balance_floor_mv;
  logic [VOLT_W-1:0]           balance_delta_mv;
  logic [VOLT_W-1:0]           overvolt_mv;
  logic [VOLT_W-1:0]           undervolt_mv;
  logic signed [TEMP_W-1:0]    overtemp_limit;
  logic [CHG_LIM_W-1:0]        charge_current_limit;
  logic signed [DIS_LIM_W-1:0] discharge_current_limit;
  logic [COUNT_W-1:0]          capacity_charge;

  // input stage
  logic                        in_valid;
  logic                        in_ready;
  cells_t                      in_cells;
  logic signed [TEMP_W-1:0]    in_temp;
  logic signed [CUR_W-1:0]     in_current;
  logic [MS_W-1:0]             in_elapsed;
  eval_t                       eval;
  logic signed [PROD_W-1:0]    product;

  // result stage
  logic                        out_valid;
  logic                        out_ready;
  eval_t                       out_eval;
  logic [COUNT_W-1:0]          count;
  logic [COUNT_W-1:0]          count_next;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SUM_W-1:0]     cap_ext;
  logic [3:0]                  fault_bits;
  logic                        charge_enable;
  logic                        discharge_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      balance_floor_mv        <= BAL_FLOOR_RST;
      balance_delta_mv        <= BAL_DELTA_RST;
      overvolt_mv             <= OVERVOLT_RST;
      undervolt_mv            <= UNDERVOLT_RST;
      overtemp_limit          <= OVERTEMP_RST;
      charge_current_limit    <= CHG_LIM_RST;
      discharge_current_limit <= DIS_LIM_RST;
      capacity_charge         <= CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BAL_FLOOR: balance_floor_mv        <= cfg_data[VOLT_W-1:0];
        REG_BAL_DELTA: balance_delta_mv        <= cfg_data[VOLT_W-1:0];
        REG_OVERVOLT:  overvolt_mv             <= cfg_data[VOLT_W-1:0];
        REG_UNDERVOLT: undervolt_mv            <= cfg_data[VOLT_W-1:0];
        REG_OVERTEMP:  overtemp_limit          <= $signed(cfg_data[TEMP_W-1:0]);
        REG_CHG_LIM:   charge_current_limit    <= cfg_data[CHG_LIM_W-1:0];
        REG_DIS_LIM:   discharge_current_limit <= $signed(cfg_data[DIS_LIM_W-1:0]);
        REG_CAPACITY:  capacity_charge         <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ready     = !out_valid || m_axis_tready;
  assign in_ready      = !in_valid || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && in_ready) begin
      in_cells[0] <= s_axis_tdata[12:0];
      in_cells[1] <= s_axis_tdata[25:13];
      in_cells[2] <= s_axis_tdata[38:26];
      in_cells[3] <= s_axis_tdata[51:39];
      in_temp     <= $signed(s_axis_tdata[63:52]);
      in_current  <= $signed(s_axis_tdata[82:64]);
      in_elapsed  <= s_axis_tdata[98:83];
    end
  end

  bpm_eval u_eval (
    .cells                   (in_cells),
    .pack_temperature        (in_temp),
    .pack_current            (in_current),
    .balance_floor_mv        (balance_floor_mv),
    .balance_delta_mv        (balance_delta_mv),
    .overvolt_mv             (overvolt_mv),
    .undervolt_mv            (undervolt_mv),
    .overtemp_limit          (overtemp_limit),
    .charge_current_limit    (charge_current_limit),
    .discharge_current_limit (discharge_current_limit),
    .result                  (eval)
  );

  // 19x17 signed multiply feeding the count add
  assign product = in_current * $signed({1'b0, in_elapsed});

  assign sum     = $signed({2'b00, count}) + SUM_W'(product);
  assign cap_ext = $signed({2'b00, capacity_charge});

  always_comb begin
    priority if (sum > cap_ext) begin
      count_next = capacity_charge;
    end else if (sum < 0) begin
      count_next = '0;
    end else begin
      count_next = sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= COUNT_RST;
    end else begin
      if (out_ready) begin
        out_valid <= in_valid;
      end
      if (in_valid && out_ready) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && out_ready) begin
      out_eval <= eval;
    end
  end

  assign fault_bits       = {out_eval.occ | out_eval.ocd, out_eval.ot, out_eval.uv, out_eval.ov};
  assign charge_enable    = !(out_eval.ov || out_eval.ot || out_eval.occ);
  assign discharge_enable = !(out_eval.uv || out_eval.ot || out_eval.ocd);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b000000, count, discharge_enable, charge_enable, fault_bits,
                          out_eval.balance_mask};

  a_level_in_capacity : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> count <= capacity_charge)
    else $error("charge level above capacity");

  a_charge_en : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && charge_enable) |-> !(fault_bits[0] || fault_bits[2]))
    else $error("charge enabled with overvoltage or overtemperature");

  a_discharge_en : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && discharge_enable) |-> !(fault_bits[1] || fault_bits[2]))
    else $error("discharge enabled with undervoltage or overtemperature");

  a_count_moves_on_load : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |-> $past(in_valid && out_ready))
    else $error("charge count changed without a result load");

endmodule

/* tb/battery_pack_monitor_tb.sv */
module battery_pack_monitor_tb;
  import bpm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PIPE_DEPTH  = 2;
  localparam int FAULT_OV    = 0;
  localparam int FAULT_UV    = 1;
  localparam int FAULT_OT    = 2;
  localparam int FAULT_OC    = 3;

  // s_axis_tdata layout, lowest bits first: cells 0..3, temperature, current, ms, pad
  typedef struct packed {
    logic [4:0]               pad;
    logic [MS_W-1:0]          elapsed_ms;
    logic signed [CUR_W-1:0]  current;
    logic signed [TEMP_W-1:0] temperature;
    cells_t                   cells;
  } tick_t;

  // m_axis_tdata layout, lowest bits first: mask, faults, enables, level, pad
  typedef struct packed {
    logic [5:0]             pad;
    logic [COUNT_W-1:0]     charge_level;
    logic                   discharge_enable;
    logic                   charge_enable;
    logic [3:0]             fault_bits;
    logic [CELL_FIELDS-1:0] balance_mask;
  } status_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // limits and charge count as the block should hold them
  volt_t                       bal_floor;
  volt_t                       bal_delta;
  volt_t                       overvolt;
  volt_t                       undervolt;
  logic signed [TEMP_W-1:0]    overtemp;
  logic [CHG_LIM_W-1:0]        chg_limit;
  logic signed [DIS_LIM_W-1:0] dis_limit;
  logic [COUNT_W-1:0]          capacity;
  logic [COUNT_W-1:0]          charge_count;

  status_t pending_status[$];
  int      mismatch_count;
  int      result_count;
  int      stall_cycles;
  int      idle_pct;

  battery_pack_monitor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Advances the charge count and works out the status of one tick.
  function automatic status_t predict_status(tick_t t);
    status_t r;
    longint  level;
    volt_t   lowest;
    logic    ov, uv, ot, occ, ocd;
    int      i;
    r = '0;
    ov = 1'b0;
    uv = 1'b0;
    level = longint'(charge_count) + longint'($signed(t.current)) * longint'(t.elapsed_ms);
    if (level > longint'(capacity)) level = longint'(capacity);
    if (level < 0) level = 0;
    charge_count = level[COUNT_W-1:0];
    lowest = t.cells[0];
    for (i = 1; i < MON_CELLS; i++) begin
      if (t.cells[i] < lowest) lowest = t.cells[i];
    end
    for (i = 0; i < MON_CELLS; i++) begin
      if (t.cells[i] > bal_floor && volt_t'(t.cells[i] - lowest) > bal_delta)
        r.balance_mask[i] = 1'b1;
      if (t.cells[i] > overvolt) ov = 1'b1;
      if (t.cells[i] < undervolt) uv = 1'b1;
    end
    ot  = $signed(t.temperature) > overtemp;
    occ = longint'($signed(t.current)) > longint'(chg_limit);
    ocd = longint'($signed(t.current)) < longint'(dis_limit);
    r.fault_bits[FAULT_OV] = ov;
    r.fault_bits[FAULT_UV] = uv;
    r.fault_bits[FAULT_OT] = ot;
    r.fault_bits[FAULT_OC] = occ | ocd;
    r.charge_enable    = !(ov || ot || occ);
    r.discharge_enable = !(uv || ot || ocd);
    r.charge_level     = charge_count;
    return r;
  endfunction

  function automatic tick_t make_tick(int c0, int c1, int c2, int c3, int temp, int cur,
                                      int ms);
    tick_t t;
    t = '0;
    t.cells[0]    = VOLT_W'(c0);
    t.cells[1]    = VOLT_W'(c1);
    t.cells[2]    = VOLT_W'(c2);
    t.cells[3]    = VOLT_W'(c3);
    t.temperature = TEMP_W'(temp);
    t.current     = CUR_W'(cur);
    t.elapsed_ms  = MS_W'(ms);
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int    base, mode, i;
    t = '0;
    mode = $urandom_range(9);
    if (mode < 2) begin
      // anything the field widths allow
      for (i = 0; i < CELL_FIELDS; i++) t.cells[i] = VOLT_W'($urandom);
      t.temperature = TEMP_W'($urandom);
      t.current     = CUR_W'($urandom);
      t.elapsed_ms  = MS_W'($urandom);
    end else begin
      base = $urandom_range(2300, 3800);
      for (i = 0; i < CELL_FIELDS; i++) begin
        if (mode == 2) t.cells[i] = VOLT_W'($urandom_range(0, 5000));
        else t.cells[i] = VOLT_W'(base +
                                   int'($urandom_range(0, ($urandom_range(1) != 0) ? 80 : 8)));
      end
      t.temperature = TEMP_W'(int'($urandom_range(0, 1650)) - 400);
      t.current     = CUR_W'(int'($urandom_range(0, 400000)) - 200000);
      t.elapsed_ms  = MS_W'(($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 2000));
    end
    return t;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch in %s of result %0d: got %0d, expected %0d",
             field, result_count, got, want);
    mismatch_count++;
  endtask

  task automatic send_tick(tick_t t);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_status.push_back(predict_status(t));
  endtask

  task automatic send_random(int n);
    repeat (n) send_tick(random_tick());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_limit(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BAL_FLOOR: bal_floor = value[VOLT_W-1:0];
      REG_BAL_DELTA: bal_delta = value[VOLT_W-1:0];
      REG_OVERVOLT:  overvolt  = value[VOLT_W-1:0];
      REG_UNDERVOLT: undervolt = value[VOLT_W-1:0];
      REG_OVERTEMP:  overtemp  = value[TEMP_W-1:0];
      REG_CHG_LIM:   chg_limit = value[CHG_LIM_W-1:0];
      REG_DIS_LIM:   dis_limit = value[DIS_LIM_W-1:0];
      REG_CAPACITY:  capacity  = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // values in register index order
  task automatic set_limits(logic [CFG_DATA_W-1:0] v [8]);
    int i;
    wait_drained();
    for (i = 0; i < 8; i++) write_limit(cfg_reg_t'(i), v[i]);
  endtask

  task automatic randomize_limits();
    logic [CFG_DATA_W-1:0] v [8];
    int i;
    v[REG_BAL_FLOOR] = CFG_DATA_W'($urandom_range(2300, 3900));
    v[REG_BAL_DELTA] = CFG_DATA_W'($urandom_range(0, 100));
    v[REG_OVERVOLT]  = CFG_DATA_W'($urandom_range(3300, 3900));
    v[REG_UNDERVOLT] = CFG_DATA_W'($urandom_range(2300, 3000));
    v[REG_OVERTEMP]  = CFG_DATA_W'(int'($urandom_range(0, 1650)) - 400);
    v[REG_CHG_LIM]   = CFG_DATA_W'($urandom_range(0, 250000));
    v[REG_DIS_LIM]   = CFG_DATA_W'(-int'($urandom_range(0, 250000)));
    case ($urandom_range(2))
      0: v[REG_CAPACITY] = CFG_DATA_W'($urandom_range(1, 2000000000));
      1: v[REG_CAPACITY] = CFG_DATA_W'($urandom_range(1, 200)) * 40'd1000000000;
      default: v[REG_CAPACITY] = CFG_DATA_W'({$urandom, $urandom});
    endcase
    for (i = 0; i < 8; i++) begin
      if ($urandom_range(7) == 0) v[i] = CFG_DATA_W'({$urandom, $urandom});
    end
    set_limits(v);
  endtask

  task automatic test_directed_ticks();
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, 0, 1000));
    // balancing exactly at floor and at delta
    send_tick(make_tick(3400, 3431, 3430, 3401, 250, 1000, 1000));
    send_tick(make_tick(3650, 3651, 3600, 3600, 250, 0, 10));
    send_tick(make_tick(2500, 2499, 2600, 2600, 250, 0, 10));
    send_tick(make_tick(3300, 3300, 3300, 3300, 550, 0, 10));
    send_tick(make_tick(3300, 3300, 3300, 3300, 551, 0, 10));
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, 50000, 10));
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, 50001, 10));
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, -100000, 10));
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, -100001, 10));
    send_tick(make_tick(0, 0, 0, 0, -2048, -262144, 65535));
    send_tick(make_tick(8191, 8191, 8191, 8191, 2047, 262143, 65535));
    send_tick(make_tick(5000, 0, 5000, 0, 1250, 200000, 0));
    send_tick(make_tick(0, 5000, 8191, 4096, -400, -200000, 1));
    // lowest cell moved through each position
    send_tick(make_tick(3440, 3480, 3480, 3480, 250, 0, 0));
    send_tick(make_tick(3480, 3440, 3480, 3480, 250, 0, 0));
    send_tick(make_tick(3480, 3480, 3440, 3480, 250, 0, 0));
    send_tick(make_tick(3480, 3480, 3480, 3440, 250, 0, 0));
  endtask

  task automatic test_capacity_clamp();
    wait_drained();
    // capacity below the present count pulls it down on the next tick
    write_limit(REG_CAPACITY, 40'd1000);
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, 0, 0));
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, 1, 500));
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, -1, 400));
    wait_drained();
    write_limit(REG_CAPACITY, 40'd0);
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, 5, 10));
    wait_drained();
    write_limit(REG_CAPACITY, '1);
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, -5, 10));
    send_tick(make_tick(3300, 3300, 3300, 3300, 250, 262143, 65535));
    wait_drained();
    write_limit(REG_CAPACITY, CAPACITY_RST);
  endtask

  task automatic test_limit_extremes();
    set_limits('{'0, '0, '0, '0, '0, '0, '0, '0});
    send_random(40);
    set_limits('{'1, '1, '1, '1, '1, '1, '1, '1});
    send_random(40);
    set_limits('{40'd5000, 40'd5000, 40'd5000, 40'd5000, 40'd1250, 40'd1000000, '0,
                 40'hFFFFFFFFFF});
    send_random(40);
    set_limits('{'0, '0, '0, '0, -40'sd400, '0, -40'sd1000000, 40'd1});
    send_random(40);
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 10; phase++) begin
      randomize_limits();
      if (phase == 3) idle_pct = 0;
      send_random(95);
      idle_pct = 24;
    end
  endtask

  // sink side backpressure
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin : check_results
    status_t got;
    status_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_status.size() == 0) begin
        report_mismatch("transaction with none pending", longint'(got), longint'(0));
      end else begin
        want = pending_status.pop_front();
        if (got.balance_mask != want.balance_mask)
          report_mismatch("balance_mask", longint'(got.balance_mask),
                          longint'(want.balance_mask));
        if (got.fault_bits != want.fault_bits)
          report_mismatch("fault_bits", longint'(got.fault_bits), longint'(want.fault_bits));
        if (got.charge_enable != want.charge_enable)
          report_mismatch("charge_enable", longint'(got.charge_enable),
                          longint'(want.charge_enable));
        if (got.discharge_enable != want.discharge_enable)
          report_mismatch("discharge_enable", longint'(got.discharge_enable),
                          longint'(want.discharge_enable));
        if (got.charge_level != want.charge_level)
          report_mismatch("charge_level", longint'(got.charge_level),
                          longint'(want.charge_level));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_BAL_FLOOR;
    cfg_data       = '0;
    mismatch_count = 0;
    result_count   = 0;
    stall_cycles   = 0;
    idle_pct       = 24;
    bal_floor      = BAL_FLOOR_RST;
    bal_delta      = BAL_DELTA_RST;
    overvolt       = OVERVOLT_RST;
    undervolt      = UNDERVOLT_RST;
    overtemp       = OVERTEMP_RST;
    chg_limit      = CHG_LIM_RST;
    dis_limit      = DIS_LIM_RST;
    capacity       = CAPACITY_RST;
    charge_count   = COUNT_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_ticks();
    test_capacity_clamp();
    test_limit_extremes();
    test_random_traffic();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
